[src/ecpr_pkg.sv]
// Shared constants and control types for the enhanced clock replacement core.
package ecpr_pkg;

  localparam int MAX_FRAMES = 8;
  localparam int PAGE_BITS  = 16;
  localparam int IDX_W      = 3;
  localparam int CFG_W      = 4;
  localparam int CNT_W      = 32;

  localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(3);

  typedef struct packed {
    logic load;
    logic match;
    logic sweep;
    logic commit;
  } cmd_t;

endpackage

[src/ecpr_ctrl.sv]
// Sequencer for the enhanced clock replacement core: load, match, sweep, commit.
module ecpr_ctrl import ecpr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  output logic done_o,
  output cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_SWEEP,
    ST_COMMIT
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= (state_q == ST_COMMIT);
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            state_q <= ST_MATCH;
            busy_q  <= 1'b1;
          end
        end
        ST_MATCH: state_q <= ST_SWEEP;
        ST_SWEEP: state_q <= ST_COMMIT;
        ST_COMMIT: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy         = busy_q;
  assign done_o       = done_q;
  assign cmd_o.load   = (state_q == ST_IDLE) && start;
  assign cmd_o.match  = (state_q == ST_MATCH);
  assign cmd_o.sweep  = (state_q == ST_SWEEP);
  assign cmd_o.commit = (state_q == ST_COMMIT);

endmodule

[src/ecpr_datapath.sv]
// Frame table, hit match, clock-hand victim pick and result registers.
module ecpr_datapath import ecpr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic [PAGE_BITS-1:0] page_number_i,
  input  logic                 is_write_i,
  output logic                 hit_o,
  output logic [IDX_W-1:0]     frame_index_o,
  output logic                 evicted_valid_o,
  output logic [PAGE_BITS-1:0] evicted_page_o,
  output logic                 evicted_dirty_o,
  output logic [CNT_W-1:0]     replacement_count_o
);

  logic [CFG_W-1:0]      cfg_q;
  logic [PAGE_BITS-1:0]  page_q;
  logic                  wr_q;
  logic [CFG_W-1:0]      n_q;
  logic [CFG_W-1:0]      n_d;

  logic [PAGE_BITS-1:0]  frame_page_q [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] valid_q;
  logic [MAX_FRAMES-1:0] ref_q;
  logic [MAX_FRAMES-1:0] mod_q;
  logic [IDX_W-1:0]      hand_q;
  logic [CFG_W-1:0]      fill_q;
  logic [CNT_W-1:0]      faults_q;

  logic                  hit_q;
  logic [IDX_W-1:0]      hit_idx_q;
  logic                  fill_sel_q;
  logic [IDX_W-1:0]      victim_q;
  logic [MAX_FRAMES-1:0] clr_q;

  logic                  hit_found;
  logic [IDX_W-1:0]      hit_idx;

  logic [IDX_W-1:0]      start_idx;
  logic [CFG_W-1:0]      pos;
  logic [IDX_W-1:0]      f;
  logic                  found_a, found_b, found_c;
  logic [IDX_W-1:0]      idx_a, idx_b, idx_c;
  logic [MAX_FRAMES-1:0] pre_b_mask;
  logic [MAX_FRAMES-1:0] managed_mask;
  logic                  fill_now;
  logic [IDX_W-1:0]      victim_d;
  logic [MAX_FRAMES-1:0] clr_d;

  logic [MAX_FRAMES-1:0] victim_oh;
  logic [CFG_W-1:0]      victim_next;
  logic [IDX_W-1:0]      hand_d;

  // Clamp the frame count into the supported range.
  always_comb begin
    n_d = cfg_q;
    if (cfg_q == '0) begin
      n_d = CFG_W'(1);
    end else if (cfg_q > CFG_W'(MAX_FRAMES)) begin
      n_d = CFG_W'(MAX_FRAMES);
    end
  end

  // Lowest managed frame holding the page wins.
  always_comb begin
    hit_found = 1'b0;
    hit_idx   = '0;
    for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
      if ((CFG_W'(i) < n_q) && valid_q[i] && (frame_page_q[i] == page_q)) begin
        hit_found = 1'b1;
        hit_idx   = IDX_W'(i);
      end
    end
  end

  // Walk the managed frames once from the hand, collecting all pass outcomes.
  always_comb begin
    start_idx    = (CFG_W'(hand_q) < n_q) ? hand_q : '0;
    found_a      = 1'b0;
    found_b      = 1'b0;
    found_c      = 1'b0;
    idx_a        = '0;
    idx_b        = '0;
    idx_c        = '0;
    pre_b_mask   = '0;
    managed_mask = '0;
    pos          = '0;
    f            = '0;
    for (int k = 0; k < MAX_FRAMES; k++) begin
      pos = CFG_W'(start_idx) + CFG_W'(k);
      if (pos >= n_q) begin
        pos = pos - n_q;
      end
      f = pos[IDX_W-1:0];
      if (CFG_W'(k) < n_q) begin
        managed_mask[f] = 1'b1;
        if (!found_a && !ref_q[f] && !mod_q[f]) begin
          found_a = 1'b1;
          idx_a   = f;
        end
        if (!found_b) begin
          if (!ref_q[f] && mod_q[f]) begin
            found_b = 1'b1;
            idx_b   = f;
          end else begin
            pre_b_mask[f] = 1'b1;
          end
        end
        if (!found_c && !mod_q[f]) begin
          found_c = 1'b1;
          idx_c   = f;
        end
      end
    end

    fill_now = (fill_q < n_q);
    victim_d = start_idx;
    clr_d    = '0;
    priority if (fill_now) begin
      victim_d = fill_q[IDX_W-1:0];
    end else if (found_a) begin
      victim_d = idx_a;
    end else if (found_b) begin
      victim_d = idx_b;
      clr_d    = pre_b_mask;
    end else if (found_c) begin
      victim_d = idx_c;
      clr_d    = managed_mask;
    end else begin
      clr_d    = managed_mask;
    end
  end

  always_comb begin
    victim_oh   = MAX_FRAMES'(1) << victim_q;
    victim_next = CFG_W'(victim_q) + CFG_W'(1);
    hand_d      = (victim_next == n_q) ? '0 : victim_next[IDX_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q    <= FRAMES_RESET;
      valid_q  <= '0;
      ref_q    <= '0;
      mod_q    <= '0;
      hand_q   <= '0;
      fill_q   <= '0;
      faults_q <= '0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_data_i;
      end
      if (cmd_i.commit) begin
        if (hit_q) begin
          ref_q[hit_idx_q] <= 1'b1;
          if (wr_q) begin
            mod_q[hit_idx_q] <= 1'b1;
          end
        end else begin
          ref_q             <= (ref_q & ~clr_q) | victim_oh;
          mod_q[victim_q]   <= wr_q;
          valid_q[victim_q] <= 1'b1;
          if (fill_sel_q) begin
            fill_q <= fill_q + CFG_W'(1);
          end else begin
            faults_q <= faults_q + CNT_W'(1);
            hand_q   <= hand_d;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      page_q <= page_number_i;
      wr_q   <= is_write_i;
      n_q    <= n_d;
    end
    if (cmd_i.match) begin
      hit_q     <= hit_found;
      hit_idx_q <= hit_idx;
    end
    if (cmd_i.sweep) begin
      fill_sel_q <= fill_now;
      victim_q   <= victim_d;
      clr_q      <= clr_d;
    end
    if (cmd_i.commit) begin
      if (hit_q) begin
        hit_o               <= 1'b1;
        frame_index_o       <= hit_idx_q;
        evicted_valid_o     <= 1'b0;
        evicted_page_o      <= '0;
        evicted_dirty_o     <= 1'b0;
        replacement_count_o <= faults_q;
      end else begin
        frame_page_q[victim_q] <= page_q;
        hit_o                  <= 1'b0;
        frame_index_o          <= victim_q;
        if (fill_sel_q) begin
          evicted_valid_o     <= 1'b0;
          evicted_page_o      <= '0;
          evicted_dirty_o     <= 1'b0;
          replacement_count_o <= faults_q;
        end else begin
          evicted_valid_o     <= 1'b1;
          evicted_page_o      <= frame_page_q[victim_q];
          evicted_dirty_o     <= mod_q[victim_q];
          replacement_count_o <= faults_q + CNT_W'(1);
        end
      end
    end
  end

endmodule

[src/enhanced_clock_page_replacement_core.sv]
// Top level of the enhanced second-chance clock page replacement core.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+------------------------------------------
//   access   | start / busy          | page_number_i, is_write_i
//   result   | done_o (1-cycle)      | hit_o, frame_index_o, evicted_valid_o,
//            |                       | evicted_page_o, evicted_dirty_o,
//            |                       | replacement_count_o
//   config   | cfg_we_i              | cfg_data_i (frames in use)
//
// An access is taken when start is high and busy is low; its result strobes on
// done_o after the match, sweep and commit steps of the sequencer. The next
// access may start in the cycle of the strobe. The victim pick is a
// combinational rotated priority search over the frames in use, up to eight,
// registered in the sweep step. Reset clears all frame bits, the hand, the
// fill count and the fault count, and sets frames in use to three. The
// receiver cannot stall the result.
module enhanced_clock_page_replacement_core import ecpr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [PAGE_BITS-1:0] page_number_i,
  input  logic                 is_write_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output logic                 done_o,
  output logic                 hit_o,
  output logic [IDX_W-1:0]     frame_index_o,
  output logic                 evicted_valid_o,
  output logic [PAGE_BITS-1:0] evicted_page_o,
  output logic                 evicted_dirty_o,
  output logic [CNT_W-1:0]     replacement_count_o
);

  cmd_t cmd;

  ecpr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  ecpr_datapath u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .cfg_we_i            (cfg_we_i),
    .cfg_data_i          (cfg_data_i),
    .page_number_i       (page_number_i),
    .is_write_i          (is_write_i),
    .hit_o               (hit_o),
    .frame_index_o       (frame_index_o),
    .evicted_valid_o     (evicted_valid_o),
    .evicted_page_o      (evicted_page_o),
    .evicted_dirty_o     (evicted_dirty_o),
    .replacement_count_o (replacement_count_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while still busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && hit_o |-> !evicted_valid_o)
    else $error("hit reported with an eviction");

endmodule
